// File: rtl/esccwm_pkg.sv
// Shared types, constants and the divider step for the command watchdog mapper.
package esccwm_pkg;

	// Field widths of the channel beats and the configuration port.
	localparam int unsigned CH_W      = 2;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned CMD_W     = 14;
	localparam int unsigned PULSE_W   = 16;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned FLAGS_W   = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	// Divider geometry: a 32-bit magnitude, two quotient bits per cycle.
	localparam int unsigned DIV_NUM_W   = 32;
	localparam int unsigned DIV_DEN_W   = 14;
	localparam int unsigned DIV_CYCLES  = DIV_NUM_W / 2;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES);

	// Counter saturation value.
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register reset values.
	localparam logic [CMD_W-1:0]   CMD_MIN_RST       = 14'sd0;
	localparam logic [CMD_W-1:0]   CMD_MAX_RST       = 14'sd8191;
	localparam logic [PULSE_W-1:0] PULSE_MIN_RST     = 16'd24286;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST     = 16'd48571;
	localparam logic [CNT_W-1:0]   FAIL_LIMIT_RST    = 8'd3;
	localparam logic [CNT_W-1:0]   RECOVER_LIMIT_RST = 8'd200;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CMD_MIN       = 3'd0,
		CFG_CMD_MAX       = 3'd1,
		CFG_PULSE_MIN     = 3'd2,
		CFG_PULSE_MAX     = 3'd3,
		CFG_FAIL_LIMIT    = 3'd4,
		CFG_RECOVER_LIMIT = 3'd5
	} cfg_reg_t;

	// One channel record in the state memory.
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [CNT_W-1:0]   miss;
		logic [CNT_W-1:0]   good;
	} chan_entry_t;

	// Result of one restoring division step.
	typedef struct packed {
		logic [DIV_DEN_W-1:0] rem;
		logic                 q;
	} div_step_t;

	// One restoring step: shift in a numerator bit, subtract when it fits.
	function automatic div_step_t div_step(input logic [DIV_DEN_W-1:0] rem,
			input logic nbit, input logic [DIV_DEN_W-1:0] den);
		logic [DIV_DEN_W:0] trial;
		div_step_t          res;
		trial = {rem, nbit};
		if (trial >= {1'b0, den}) begin
			res.rem = DIV_DEN_W'(trial - {1'b0, den});
			res.q   = 1'b1;
		end else begin
			res.rem = trial[DIV_DEN_W-1:0];
			res.q   = 1'b0;
		end
		return res;
	endfunction

endpackage

// File: rtl/esc_command_watchdog_mapper.sv
// Command watchdog with failsafe and linear PWM mapping, top level.
//
// Each input beat (channel, update_stamp, command) is one periodic check of a
// motor channel. The block compares the stamp with the one stored for that
// channel in a small state memory and returns exactly one output beat: the
// channel, whether a compare value must be written, the compare value, the
// channel's error flag and the error flags of all channels.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. One check is processed at a time: in_stall is high from the
// cycle after acceptance until the result is loaded into the output register.
// From acceptance, a miss, an absent channel or a zero input span passes through
// the evaluate and done states; a mapped command passes through evaluate,
// multiply, absolute value, divide, fix-up and done. The serial divider
// retires two quotient bits per cycle.
// A finished result waits in the output register while the receiver stalls;
// the next check is accepted meanwhile, and its result is held back until
// the output register is free.
// Reset clears all stored stamps, counters and error flags (through per-entry
// valid bits) and loads the register reset values. Configuration writes are
// to be made only while the block is idle; the block itself does not enforce this.
module esc_command_watchdog_mapper
	import esccwm_pkg::*;
#(
	parameter int unsigned CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port
	input  logic                        cfg_write,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [CH_W-1:0]             channel,
	input  logic [STAMP_W-1:0]          update_stamp,
	input  logic signed [CMD_W-1:0]     command,
	// Output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [CH_W-1:0]             out_channel,
	output logic                        write_pulse,
	output logic [PULSE_W-1:0]          pulse,
	output logic                        channel_error,
	output logic [FLAGS_W-1:0]          error_flags
);

	// Only channels reachable through the 2-bit index get storage.
	localparam int unsigned DEPTH  = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CH_W:0] DEPTH_C = (CH_W + 1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_ABS,
		S_DIV,
		S_FIX,
		S_DONE
	} state_t;

	state_t state_q;

	// Registers
	logic signed [CMD_W-1:0]  cmd_min_q;
	logic signed [CMD_W-1:0]  cmd_max_q;
	logic [PULSE_W-1:0]       pulse_min_q;
	logic [PULSE_W-1:0]       pulse_max_q;
	logic [CNT_W-1:0]         fail_limit_q;
	logic [CNT_W-1:0]         recover_limit_q;

	// Request held for the duration of one check
	logic [CH_W-1:0]          ch_q;
	logic [STAMP_W-1:0]       stamp_q;
	logic signed [CMD_W-1:0]  cmd_q;

	// State memory, its read register and per-entry valid bits
	chan_entry_t              mem [DEPTH];
	chan_entry_t              rd_entry_s1;
	logic [DEPTH-1:0]         ent_valid_q;
	logic [DEPTH-1:0]         fault_q;

	// Mapping datapath
	logic signed [PULSE_W-1:0]   diff_q;
	logic signed [2*PULSE_W:0]   prod_q;
	logic [DIV_NUM_W-1:0]        num_q;
	logic [DIV_DEN_W-1:0]        den_q;
	logic [DIV_DEN_W-1:0]        rem_q;
	logic                        quot_neg_q;
	logic [DIV_CNT_W-1:0]        div_cnt_q;

	// Result waiting for the output register
	logic                     res_write_q;
	logic [PULSE_W-1:0]       res_pulse_q;

	// Output register
	logic                     out_valid_q;
	logic [CH_W-1:0]          out_channel_q;
	logic                     write_pulse_q;
	logic [PULSE_W-1:0]       pulse_q;
	logic                     channel_error_q;
	logic [FLAGS_W-1:0]       error_flags_q;

	logic                     in_beat;
	logic [ADDR_W-1:0]        addr;
	logic [ADDR_W-1:0]        in_addr;
	logic                     present;
	logic                     in_present;
	chan_entry_t              cur_entry;
	chan_entry_t              new_entry;
	logic                     is_new;
	logic [CNT_W-1:0]         good_next;
	logic [CNT_W-1:0]         miss_next;
	logic [DEPTH-1:0]         fault_next;
	logic                     fail_hit;
	logic [CMD_W:0]           mag;
	logic signed [PULSE_W-1:0] diff_next;
	logic signed [PULSE_W:0]  span_out;
	logic signed [CMD_W:0]    span_in;
	logic                     mem_we;
	div_step_t                dstep_a;
	div_step_t                dstep_b;
	logic signed [DIV_NUM_W+1:0] quot_s;
	logic signed [DIV_NUM_W+1:0] mapped;
	logic [PULSE_W-1:0]       clamped;
	logic                     out_free;
	logic [FLAGS_W-1:0]       flags_now;

	assign in_beat    = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign in_addr    = channel[ADDR_W-1:0];
	assign in_present = ({1'b0, channel} < DEPTH_C);
	assign addr       = ch_q[ADDR_W-1:0];
	assign present    = ({1'b0, ch_q} < DEPTH_C);
	assign out_free   = !out_valid_q || !out_stall;

	// Spans of the linear map, from the registers that stay put during a check.
	assign span_in  = {cmd_max_q[CMD_W-1], cmd_max_q} - {cmd_min_q[CMD_W-1], cmd_min_q};
	assign span_out = $signed({1'b0, pulse_max_q}) - $signed({1'b0, pulse_min_q});

	// Read-modify-write of the addressed channel record.
	always_comb begin
		cur_entry  = ent_valid_q[addr] ? rd_entry_s1 : '0;
		is_new     = (stamp_q != cur_entry.stamp);
		good_next  = (cur_entry.good == CNT_MAX) ? CNT_MAX : cur_entry.good + 1'b1;
		miss_next  = (cur_entry.miss == CNT_MAX) ? CNT_MAX : cur_entry.miss + 1'b1;
		fail_hit   = (miss_next >= fail_limit_q);
		new_entry  = cur_entry;
		fault_next = fault_q;
		if (is_new) begin
			new_entry.stamp = stamp_q;
			new_entry.miss  = '0;
			new_entry.good  = good_next;
			if (good_next > recover_limit_q) begin
				fault_next[addr] = 1'b0;
			end
		end else begin
			new_entry.good = '0;
			new_entry.miss = miss_next;
			if (fail_hit) begin
				fault_next[addr] = 1'b1;
			end
		end
		mem_we = (state_q == S_EVAL) && present;
	end

	// Command magnitude and its offset from cmd_min.
	assign mag       = cmd_q[CMD_W-1] ? ((CMD_W + 1)'(0) - {cmd_q[CMD_W-1], cmd_q})
	                                  : {1'b0, cmd_q};
	assign diff_next = $signed({1'b0, mag}) - $signed({{2{cmd_min_q[CMD_W-1]}}, cmd_min_q});

	// Two restoring steps per divider cycle.
	assign dstep_a = div_step(rem_q, num_q[DIV_NUM_W-1], den_q);
	assign dstep_b = div_step(dstep_a.rem, num_q[DIV_NUM_W-2], den_q);

	// Signed quotient plus pulse_min, clamped to the compare range.
	always_comb begin
		quot_s = quot_neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		mapped = quot_s + $signed({{(DIV_NUM_W + 2 - PULSE_W){1'b0}}, pulse_min_q});
		if (mapped[DIV_NUM_W+1]) begin
			clamped = '0;
		end else if (|mapped[DIV_NUM_W:PULSE_W]) begin
			clamped = '1;
		end else begin
			clamped = mapped[PULSE_W-1:0];
		end
	end

	// Error flags of all channels as seen on the output.
	always_comb begin
		flags_now = '0;
		for (int i = 0; i < DEPTH; i++) begin
			flags_now[i] = fault_q[i];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_min_q       <= CMD_MIN_RST;
			cmd_max_q       <= CMD_MAX_RST;
			pulse_min_q     <= PULSE_MIN_RST;
			pulse_max_q     <= PULSE_MAX_RST;
			fail_limit_q    <= FAIL_LIMIT_RST;
			recover_limit_q <= RECOVER_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CMD_MIN:       cmd_min_q       <= cfg_data[CMD_W-1:0];
				CFG_CMD_MAX:       cmd_max_q       <= cfg_data[CMD_W-1:0];
				CFG_PULSE_MIN:     pulse_min_q     <= cfg_data[PULSE_W-1:0];
				CFG_PULSE_MAX:     pulse_max_q     <= cfg_data[PULSE_W-1:0];
				CFG_FAIL_LIMIT:    fail_limit_q    <= cfg_data[CNT_W-1:0];
				CFG_RECOVER_LIMIT: recover_limit_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// State memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= new_entry;
		end
		if (in_beat && in_present) begin
			rd_entry_s1 <= mem[in_addr];
		end
	end

	// Request capture and the mapping datapath.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			ch_q    <= channel;
			stamp_q <= update_stamp;
			cmd_q   <= command;
		end
		case (state_q)
			S_EVAL: begin
				diff_q <= diff_next;
			end
			S_MUL: begin
				prod_q <= $signed({{(PULSE_W + 1){diff_q[PULSE_W-1]}}, diff_q})
				        * $signed({{PULSE_W{span_out[PULSE_W]}}, span_out});
			end
			S_ABS: begin
				quot_neg_q <= prod_q[2*PULSE_W] ^ span_in[CMD_W];
				num_q      <= prod_q[2*PULSE_W] ? DIV_NUM_W'((2*PULSE_W + 1)'(0) - prod_q)
				                                : prod_q[DIV_NUM_W-1:0];
				den_q      <= span_in[CMD_W] ? DIV_DEN_W'((CMD_W + 1)'(0) - span_in)
				                             : span_in[DIV_DEN_W-1:0];
				rem_q      <= '0;
			end
			S_DIV: begin
				num_q <= {num_q[DIV_NUM_W-3:0], dstep_a.q, dstep_b.q};
				rem_q <= dstep_b.rem;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, watchdog flags and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			ent_valid_q     <= '0;
			fault_q         <= '0;
			div_cnt_q       <= '0;
			res_write_q     <= 1'b0;
			res_pulse_q     <= '0;
			out_valid_q     <= 1'b0;
			out_channel_q   <= '0;
			write_pulse_q   <= 1'b0;
			pulse_q         <= '0;
			channel_error_q <= 1'b0;
			error_flags_q   <= '0;
		end else begin
			// A taken beat empties the output register unless a new one loads it.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (present) begin
						ent_valid_q[addr] <= 1'b1;
						fault_q           <= fault_next;
					end
					res_write_q <= present && (is_new || fail_hit);
					res_pulse_q <= (present && is_new && span_in == '0) ? pulse_min_q : '0;
					if (present && is_new && span_in != '0) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ABS;
				end
				S_ABS: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					res_pulse_q <= clamped;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						out_channel_q   <= ch_q;
						write_pulse_q   <= res_write_q;
						pulse_q         <= res_pulse_q;
						channel_error_q <= present && fault_q[addr];
						error_flags_q   <= flags_now;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_channel   = out_channel_q;
	assign write_pulse   = write_pulse_q;
	assign pulse         = pulse_q;
	assign channel_error = channel_error_q;
	assign error_flags   = error_flags_q;

	// An accepted beat closes the input until its result is handed over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input accepted again while a check was in progress");

	// A nonzero compare value is only ever reported together with a write.
	a_pulse_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pulse != '0) |-> write_pulse)
		else $error("nonzero pulse without write_pulse");

	// The channel flag agrees with its bit in the flag vector.
	a_flag_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && channel_error) |-> error_flags[out_channel])
		else $error("channel_error set but its flag bit is clear");

	// When its step counter reaches the last step, the divider hands over to the state that finishes the map.
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) |=> (state_q == S_FIX))
		else $error("divider did not hand over to the final stage");

endmodule

// File: bench/tb_esc_command_watchdog_mapper.sv
// Self-checking testbench for the command watchdog mapper: directed table, then random bursts.
module tb_esc_command_watchdog_mapper;
	import esccwm_pkg::*;

	localparam int CHANS         = 4;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 85;
	localparam int LONG_RUN      = 260;

	// One output beat, in port order.
	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic               wr;
		logic [PULSE_W-1:0] pulse;
		logic               cerr;
		logic [FLAGS_W-1:0] flags;
	} esc_result_t;

	// One row of the directed table: a register write or a check beat.
	typedef struct {
		bit               is_cfg;
		cfg_reg_t         idx;
		int               val;
		logic [CH_W-1:0]  ch;
		logic [31:0]      stamp;
		int               cmd;
		bit               typed;
		esc_result_t      want;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DAT_W-1:0]    cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [CH_W-1:0]         channel;
	logic [STAMP_W-1:0]      update_stamp;
	logic signed [CMD_W-1:0] command;
	logic                    out_valid;
	logic                    out_stall;
	logic [CH_W-1:0]         out_channel;
	logic                    write_pulse;
	logic [PULSE_W-1:0]      pulse;
	logic                    channel_error;
	logic [FLAGS_W-1:0]      error_flags;

	esc_command_watchdog_mapper #(.CHANNELS(CHANS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.channel(channel), .update_stamp(update_stamp), .command(command),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_channel(out_channel), .write_pulse(write_pulse), .pulse(pulse),
		.channel_error(channel_error), .error_flags(error_flags)
	);

	// Mirror of the watchdog state and the register file.
	logic [STAMP_W-1:0] last_stamp [CHANS];
	logic [CNT_W-1:0]   misses [CHANS];
	logic [CNT_W-1:0]   goods [CHANS];
	logic [FLAGS_W-1:0] faults;
	int                 cmd_lo, cmd_hi, pulse_lo, pulse_hi, fail_lim, rec_lim;

	esc_result_t pending_results [$];
	plan_row_t   plan [$];
	int          snd_idle_pct;
	int          rcv_idle_pct;
	int          hold_left;
	int          mismatches;
	int          results_seen;
	int          n_fresh, n_stale, n_failsafe, n_settings;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb_esc_command_watchdog_mapper NOT OK");
		$finish;
	end

	// Expected outcome of one watchdog check; advances the mirrored state.
	function automatic esc_result_t watchdog_predict(logic [CH_W-1:0] ch,
			logic [STAMP_W-1:0] stamp, int cmd);
		esc_result_t r;
		int          mag;
		longint      span_in;
		longint      mapped;
		r.ch    = ch;
		r.wr    = 1'b0;
		r.pulse = '0;
		if (stamp != last_stamp[ch]) begin
			n_fresh++;
			last_stamp[ch] = stamp;
			misses[ch] = '0;
			if (goods[ch] != CNT_MAX)
				goods[ch]++;
			if (goods[ch] > rec_lim)
				faults[ch] = 1'b0;
			mag = (cmd < 0) ? -cmd : cmd;
			span_in = longint'(cmd_hi) - longint'(cmd_lo);
			if (span_in == 0) begin
				mapped = pulse_lo;
			end else begin
				mapped = (longint'(mag) - cmd_lo) * (longint'(pulse_hi) - pulse_lo)
					/ span_in + pulse_lo;
			end
			if (mapped < 0)
				mapped = 0;
			if (mapped > 65535)
				mapped = 65535;
			r.pulse = PULSE_W'(mapped);
			r.wr    = 1'b1;
		end else begin
			n_stale++;
			goods[ch] = '0;
			if (misses[ch] != CNT_MAX)
				misses[ch]++;
			if (misses[ch] >= fail_lim) begin
				faults[ch] = 1'b1;
				r.wr = 1'b1;
				n_failsafe++;
			end
		end
		r.cerr  = faults[ch];
		r.flags = faults;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(cfg_reg_t idx, int val);
		plan_row_t row;
		row = '{idx: CFG_CMD_MIN, default: '0};
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.val    = val;
		return row;
	endfunction

	function automatic plan_row_t beat_row(logic [CH_W-1:0] ch, logic [31:0] stamp, int cmd,
			bit typed, esc_result_t want);
		plan_row_t row;
		row = '{idx: CFG_CMD_MIN, default: '0};
		row.idx   = CFG_CMD_MIN;
		row.ch    = ch;
		row.stamp = stamp;
		row.cmd   = cmd;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Register write through the configuration port, mirrored at once.
	task automatic set_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DAT_W'(val);
		case (idx)
			CFG_CMD_MIN:       cmd_lo   = int'($signed(val[CMD_W-1:0]));
			CFG_CMD_MAX:       cmd_hi   = int'($signed(val[CMD_W-1:0]));
			CFG_PULSE_MIN:     pulse_lo = int'(val[PULSE_W-1:0]);
			CFG_PULSE_MAX:     pulse_hi = int'(val[PULSE_W-1:0]);
			CFG_FAIL_LIMIT:    fail_lim = int'(val[CNT_W-1:0]);
			CFG_RECOVER_LIMIT: rec_lim  = int'(val[CNT_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Offers one check beat, after a random gap, and records its expected result.
	task automatic push_check(logic [CH_W-1:0] ch, logic [31:0] stamp, int cmd,
			bit typed, esc_result_t want);
		int          gap;
		esc_result_t pred;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct && gap < 20)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		channel      <= ch;
		update_stamp <= stamp;
		command      <= CMD_W'(cmd);
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = watchdog_predict(ch, stamp, cmd);
		pending_results.push_back(typed ? want : pred);
	endtask

	// Stops offering beats and waits until every expected result has come.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random check: either a new stamp or the stored one repeated.
	task automatic random_check(logic [CH_W-1:0] ch, bit fresh);
		logic [31:0] stamp;
		int          cmd;
		if (fresh) begin
			case ($urandom_range(0, 3))
				0:       stamp = '0;
				1:       stamp = '1;
				default: stamp = $urandom;
			endcase
			if (stamp == last_stamp[ch])
				stamp = ~stamp;
		end else begin
			stamp = last_stamp[ch];
		end
		case ($urandom_range(0, 7))
			0:       cmd = -8192;
			1:       cmd = 8191;
			2:       cmd = 0;
			default: cmd = int'($urandom_range(0, 16383)) - 8192;
		endcase
		push_check(ch, stamp, cmd, 1'b0, '0);
	endtask

	// Receiver stall: a requested hold-off first, otherwise random.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		esc_result_t got;
		esc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {out_channel, write_pulse, pulse, channel_error, error_flags};
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: ch %0d wr %0b pulse %0d err %0b flags %b",
						got.ch, got.wr, got.pulse, got.cerr, got.flags);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: ch %0d/%0d wr %0b/%0b pulse %0d/%0d err %0b/%0b ",
							"flags %b/%b (expected/actual)"},
							want.ch, got.ch, want.wr, got.wr, want.pulse, got.pulse,
							want.cerr, got.cerr, want.flags, got.flags);
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int lo, hi, pl, ph, fl, rl;
		int n, len, kind;
		logic [CH_W-1:0] ch;

		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = CFG_CMD_MIN;
		cfg_data     = '0;
		in_valid     = 1'b0;
		channel      = '0;
		update_stamp = '0;
		command      = '0;
		hold_left    = 0;
		mismatches   = 0;
		results_seen = 0;
		n_fresh      = 0;
		n_stale      = 0;
		n_failsafe   = 0;
		n_settings   = 1;
		snd_idle_pct = 36;
		rcv_idle_pct = 45;
		for (int k = 0; k < CHANS; k++) begin
			last_stamp[k] = '0;
			misses[k]     = '0;
			goods[k]      = '0;
		end
		faults   = '0;
		cmd_lo   = int'($signed(CMD_MIN_RST));
		cmd_hi   = int'($signed(CMD_MAX_RST));
		pulse_lo = int'(PULSE_MIN_RST);
		pulse_hi = int'(PULSE_MAX_RST);
		fail_lim = int'(FAIL_LIMIT_RST);
		rec_lim  = int'(RECOVER_LIMIT_RST);

		// Directed table, starting from the reset register values.
		// Stamp zero after reset is a miss; the third miss trips the failsafe.
		plan.push_back(beat_row(0, 32'h0, 0, 1, '{0, 0, 0, 0, 4'b0000}));
		plan.push_back(beat_row(0, 32'h0, 8191, 1, '{0, 0, 0, 0, 4'b0000}));
		plan.push_back(beat_row(0, 32'h0, -1, 1, '{0, 1, 0, 1, 4'b0001}));
		// Command extremes on the default mapping.
		plan.push_back(beat_row(1, 32'hFFFF_FFFF, 8191, 1, '{1, 1, 48571, 0, 4'b0001}));
		plan.push_back(beat_row(2, 32'h1, -8192, 0, '0));
		plan.push_back(beat_row(3, 32'h8000_0000, 0, 1, '{3, 1, 24286, 0, 4'b0001}));
		plan.push_back(beat_row(0, 32'h5, 4096, 0, '0));
		plan.push_back(beat_row(3, 32'h8000_0000, 0, 0, '0));
		// Zero input span gives pulse_min.
		plan.push_back(cfg_row(CFG_CMD_MIN, 100));
		plan.push_back(cfg_row(CFG_CMD_MAX, 100));
		plan.push_back(beat_row(1, 32'h2, -5, 1, '{1, 1, 24286, 0, 4'b0001}));
		// A steep map clamps at both ends.
		plan.push_back(cfg_row(CFG_CMD_MIN, 1));
		plan.push_back(cfg_row(CFG_CMD_MAX, 2));
		plan.push_back(cfg_row(CFG_PULSE_MIN, 0));
		plan.push_back(cfg_row(CFG_PULSE_MAX, 65535));
		plan.push_back(beat_row(2, 32'h2, 0, 1, '{2, 1, 0, 0, 4'b0001}));
		plan.push_back(beat_row(2, 32'h3, 8191, 1, '{2, 1, 65535, 0, 4'b0001}));
		// A falling map whose quotient truncates toward zero.
		plan.push_back(cfg_row(CFG_CMD_MIN, 0));
		plan.push_back(cfg_row(CFG_CMD_MAX, 3));
		plan.push_back(cfg_row(CFG_PULSE_MIN, 10));
		plan.push_back(cfg_row(CFG_PULSE_MAX, 0));
		plan.push_back(beat_row(1, 32'h3, -1, 1, '{1, 1, 7, 0, 4'b0001}));
		// Fail limit one, then zero: every miss fails safe.
		plan.push_back(cfg_row(CFG_FAIL_LIMIT, 1));
		plan.push_back(beat_row(2, 32'h3, 0, 1, '{2, 1, 0, 1, 4'b0101}));
		plan.push_back(cfg_row(CFG_FAIL_LIMIT, 0));
		plan.push_back(beat_row(1, 32'h3, 0, 1, '{1, 1, 0, 1, 4'b0111}));
		plan.push_back(beat_row(3, 32'h8000_0000, 0, 1, '{3, 1, 0, 1, 4'b1111}));
		// Recovery limit zero clears the error on the next good update.
		plan.push_back(cfg_row(CFG_RECOVER_LIMIT, 0));
		plan.push_back(beat_row(0, 32'h6, 8191, 1, '{0, 1, 0, 0, 4'b1110}));
		plan.push_back(cfg_row(CFG_RECOVER_LIMIT, 254));
		plan.push_back(beat_row(3, 32'h0, 1, 0, '0));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; register writes wait for an idle block.
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				set_reg(plan[i].idx, plan[i].val);
				n_settings++;
			end else begin
				push_check(plan[i].ch, plan[i].stamp, plan[i].cmd, plan[i].typed,
					plan[i].want);
			end
		end

		// Random phases, each under its own register setting and one of three idle patterns.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				snd_idle_pct = 36;
				rcv_idle_pct = 45;
			end else if (p < 6) begin
				snd_idle_pct = 45;
				rcv_idle_pct = 36;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case (p)
				0: begin
					lo = 0; hi = 8191; pl = 24286; ph = 48571; fl = 3; rl = 200;
				end
				1: begin
					lo = -8192; hi = 8191; pl = 0; ph = 65535; fl = 255; rl = 254;
				end
				2: begin
					lo = 8191; hi = -8192; pl = 65535; ph = 0; fl = 1; rl = 0;
				end
				default: begin
					lo = int'($urandom_range(0, 16383)) - 8192;
					hi = (p == 5) ? lo : int'($urandom_range(0, 16383)) - 8192;
					pl = $urandom_range(0, 65535);
					ph = $urandom_range(0, 65535);
					fl = $urandom_range(1, 6);
					rl = $urandom_range(0, 12);
				end
			endcase
			settle();
			set_reg(CFG_CMD_MIN, lo);
			set_reg(CFG_CMD_MAX, hi);
			set_reg(CFG_PULSE_MIN, pl);
			set_reg(CFG_PULSE_MAX, ph);
			set_reg(CFG_FAIL_LIMIT, fl);
			set_reg(CFG_RECOVER_LIMIT, rl);
			n_settings++;

			// Long runs on one channel drive both counters into saturation.
			if (p == 1) begin
				ch = CH_W'($urandom_range(0, CHANS - 1));
				repeat (LONG_RUN) random_check(ch, 1'b1);
				repeat (LONG_RUN) random_check(ch, 1'b0);
			end

			// Bursts of good updates, of misses, or a mix over all channels.
			n = 0;
			while (n < PHASE_BEATS) begin
				ch   = CH_W'($urandom_range(0, CHANS - 1));
				kind = $urandom_range(0, 9);
				len  = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					if (kind >= 7)
						ch = CH_W'($urandom_range(0, CHANS - 1));
					random_check(ch, (kind <= 3) ? 1'b1 :
						(kind <= 6) ? 1'b0 : 1'($urandom_range(0, 1)));
					n++;
					if (n == 40 && p == 3)
						hold_left = 300;
					if (n == 40 && p == 4)
						settle();
				end
			end
		end

		settle();
		$display("Ran %0d checks (%0d good updates, %0d misses, %0d failsafe writes)",
			n_fresh + n_stale, n_fresh, n_stale, n_failsafe);
		$display("under %0d register settings; %0d result beats compared, %0d mismatches.",
			n_settings, results_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_esc_command_watchdog_mapper OK");
		end else begin
			$display("tb_esc_command_watchdog_mapper NOT OK");
		end
		$finish;
	end

endmodule
